[src/mstt_pkg.sv]
`timescale 1ns / 1ps
package mstt_pkg;

  localparam int SLOT_COUNT_DEF  = 16;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [2:0] MODE_TICK      = 3'd0;
  localparam logic [2:0] MODE_START_PER = 3'd1;
  localparam logic [2:0] MODE_START_ONE = 3'd2;
  localparam logic [2:0] MODE_RESTART   = 3'd3;
  localparam logic [2:0] MODE_STOP      = 3'd4;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_START,
    CMD_RESTART,
    CMD_STOP,
    CMD_REFUSE
  } cmd_kind_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] timer_handle;
    logic [31:0] user_tag;
    logic [31:0] period_ticks;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic        ok;
    logic [3:0]  slot_index;
    logic [15:0] out_handle;
    logic [31:0] out_tag;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        reload;
    logic [15:0] handle;
    logic [31:0] tag;
    logic [31:0] period;
  } cmd_t;

endpackage

[src/mstt_front.sv]
`timescale 1ns / 1ps
module mstt_front #(
  parameter int HANDLE_BITS = mstt_pkg::HANDLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  mstt_pkg::in_item_t in_item,
  output logic               busy,
  input  logic               q_full,
  output logic               q_push,
  output mstt_pkg::cmd_t     q_wdata
);
  import mstt_pkg::*;

  localparam logic [15:0] HandleMask = (HANDLE_BITS >= 16) ? 16'hFFFF :
                                       16'((32'd1 << HANDLE_BITS) - 32'd1);

  logic  front_vld_r, front_vld_nxt;
  cmd_t  front_cmd_r, front_cmd_nxt;
  cmd_t  cls_cmd;
  logic  cls_keep;
  logic  take;
  logic  [15:0] handle_m;

  assign q_push  = front_vld_r && !q_full;
  assign q_wdata = front_cmd_r;
  assign busy    = front_vld_r && q_full;
  assign take    = start && !busy;
  assign handle_m = in_item.timer_handle & HandleMask;

  always_comb begin
    cls_keep       = 1'b1;
    cls_cmd.kind   = CMD_TICK;
    cls_cmd.reload = 1'b0;
    cls_cmd.handle = handle_m;
    cls_cmd.tag    = in_item.user_tag;
    cls_cmd.period = in_item.period_ticks;
    case (in_item.mode)
      MODE_TICK:      cls_cmd.kind = CMD_TICK;
      MODE_START_PER: begin
        cls_cmd.kind   = CMD_START;
        cls_cmd.reload = 1'b1;
      end
      MODE_START_ONE: cls_cmd.kind = CMD_START;
      MODE_RESTART:   cls_cmd.kind = CMD_RESTART;
      MODE_STOP:      cls_cmd.kind = CMD_STOP;
      default:        cls_keep = 1'b0;
    endcase
    // null handle on any command but a tick is refused without touching the table
    if (in_item.mode != MODE_TICK && handle_m == 16'd0) begin
      cls_cmd.kind = CMD_REFUSE;
    end
  end

  always_comb begin
    front_vld_nxt = front_vld_r && !q_push;
    front_cmd_nxt = front_cmd_r;
    if (take && cls_keep) begin
      front_vld_nxt = 1'b1;
      front_cmd_nxt = cls_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_vld_r <= 1'b0;
    end else begin
      front_vld_r <= front_vld_nxt;
    end
    front_cmd_r <= front_cmd_nxt;
  end

endmodule

[src/mstt_queue.sv]
`timescale 1ns / 1ps
module mstt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mstt_pkg::cmd_t wdata,
  input  logic           pop,
  output mstt_pkg::cmd_t rdata,
  output logic           full,
  output logic           empty
);
  import mstt_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t             q_mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (PtrW + 1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = q_mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[src/mstt_back.sv]
`timescale 1ns / 1ps
module mstt_back #(
  parameter int SLOT_COUNT  = mstt_pkg::SLOT_COUNT_DEF,
  parameter int HANDLE_BITS = mstt_pkg::HANDLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  mstt_pkg::cmd_t q_rdata,
  output logic           q_pop,
  output logic           out_valid,
  output mstt_pkg::res_t out_item
);
  import mstt_pkg::*;

  localparam int IdxW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int HandleW = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [31:0]        tag;
    logic [31:0]        period;
    logic [31:0]        remain;
    logic               reload;
  } slot_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_t;

  localparam res_t FailReply = '{kind: KIND_REPLY, ok: 1'b0, slot_index: 4'd0,
                                 out_handle: 16'd0, out_tag: 32'd0,
                                 last_of_run: 1'b1};

  // slot table: one write and one read port, read data registered
  slot_t mem [SLOT_COUNT];
  slot_t rd_data_r;
  logic  rd_live_r;
  logic  [IdxW-1:0] rd_addr;
  logic  mem_we;
  slot_t mem_wdata;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [IdxW:0]     rd_idx_r, rd_idx_nxt;
  logic              ex_vld_r, ex_vld_nxt;
  logic [IdxW-1:0]   ex_idx_r, ex_idx_nxt;
  logic [SLOT_COUNT-1:0] slot_valid_r, slot_valid_nxt;
  logic              hold_vld_r, hold_vld_nxt;
  res_t              hold_r, hold_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_vld_r, out_vld_nxt;
  res_t              out_res_r, out_res_nxt;

  slot_t             ent;
  logic              is_last;
  logic              match;
  logic [31:0]       dec;
  logic              new_exp;
  res_t              hit_res;

  assign out_valid = out_vld_r;
  assign out_item  = out_res_r;
  assign rd_addr   = rd_idx_r[IdxW-1:0];

  always_comb begin
    // a slot without its valid flag reads as the cleared entry
    ent     = rd_live_r ? rd_data_r : '0;
    is_last = (ex_idx_r == IdxW'(SLOT_COUNT - 1));
    match   = rd_live_r && (ent.handle == cmd_r.handle[HandleW-1:0]);
    dec     = ent.remain - 32'd1;
    hit_res.kind        = KIND_REPLY;
    hit_res.ok          = 1'b1;
    hit_res.slot_index  = 4'(ex_idx_r);
    hit_res.out_handle  = 16'(ent.handle);
    hit_res.out_tag     = ent.tag;
    hit_res.last_of_run = 1'b1;

    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    rd_idx_nxt     = rd_idx_r;
    ex_vld_nxt     = 1'b0;
    ex_idx_nxt     = ex_idx_r;
    slot_valid_nxt = slot_valid_r;
    hold_vld_nxt   = hold_vld_r;
    hold_nxt       = hold_r;
    cnt_nxt        = cnt_r;
    out_vld_nxt    = 1'b0;
    out_res_nxt    = out_res_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_wdata      = ent;
    new_exp        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          cmd_nxt      = q_rdata;
          rd_idx_nxt   = '0;
          hold_vld_nxt = 1'b0;
          cnt_nxt      = '0;
          if (q_rdata.kind == CMD_REFUSE) begin
            out_vld_nxt = 1'b1;
            out_res_nxt = FailReply;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (rd_idx_r < (IdxW + 1)'(SLOT_COUNT)) begin
          ex_vld_nxt = 1'b1;
          ex_idx_nxt = rd_idx_r[IdxW-1:0];
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (ex_vld_r) begin
          case (cmd_r.kind)
            CMD_START: begin
              if (!rd_live_r) begin
                mem_we           = 1'b1;
                mem_wdata.handle = cmd_r.handle[HandleW-1:0];
                mem_wdata.tag    = cmd_r.tag;
                mem_wdata.period = cmd_r.period;
                mem_wdata.remain = cmd_r.period;
                mem_wdata.reload = cmd_r.reload;
                slot_valid_nxt[ex_idx_r] = 1'b1;
                out_vld_nxt = 1'b1;
                out_res_nxt = hit_res;
                out_res_nxt.out_handle = 16'(cmd_r.handle[HandleW-1:0]);
                out_res_nxt.out_tag    = cmd_r.tag;
                ex_vld_nxt  = 1'b0;
                state_nxt   = S_IDLE;
              end else if (is_last) begin
                out_vld_nxt = 1'b1;
                out_res_nxt = FailReply;
                ex_vld_nxt  = 1'b0;
                state_nxt   = S_IDLE;
              end
            end

            CMD_RESTART: begin
              if (match) begin
                mem_we           = 1'b1;
                mem_wdata.remain = ent.period;
                out_vld_nxt = 1'b1;
                out_res_nxt = hit_res;
                ex_vld_nxt  = 1'b0;
                state_nxt   = S_IDLE;
              end else if (is_last) begin
                out_vld_nxt = 1'b1;
                out_res_nxt = FailReply;
                ex_vld_nxt  = 1'b0;
                state_nxt   = S_IDLE;
              end
            end

            CMD_STOP: begin
              if (match) begin
                slot_valid_nxt[ex_idx_r] = 1'b0;
                if (!hold_vld_r) begin
                  hold_vld_nxt = 1'b1;
                  hold_nxt     = hit_res;
                end
              end
              if (is_last) begin
                out_vld_nxt = 1'b1;
                if (hold_vld_r) begin
                  out_res_nxt = hold_r;
                end else if (match) begin
                  out_res_nxt = hit_res;
                end else begin
                  out_res_nxt = FailReply;
                end
                hold_vld_nxt = 1'b0;
                ex_vld_nxt   = 1'b0;
                state_nxt    = S_IDLE;
              end
            end

            CMD_TICK: begin
              if (rd_live_r && ent.remain != 32'd0) begin
                mem_we = 1'b1;
                mem_wdata.remain = dec;
                if (dec == 32'd0) begin
                  if (ent.reload) begin
                    mem_wdata.remain = ent.period;
                  end
                  if (cnt_r < CNT_W'(MAX_RESULTS)) begin
                    new_exp = 1'b1;
                    cnt_nxt = cnt_r + 1'b1;
                  end
                end
              end
              // one expiry is held back so the final one can carry last_of_run
              if (new_exp) begin
                hold_nxt      = hit_res;
                hold_nxt.kind = KIND_EXPIRY;
                hold_vld_nxt  = 1'b1;
                if (hold_vld_r) begin
                  out_vld_nxt = 1'b1;
                  out_res_nxt = hold_r;
                  out_res_nxt.last_of_run = 1'b0;
                end
              end
              if (is_last) begin
                ex_vld_nxt = 1'b0;
                if (new_exp && hold_vld_r) begin
                  state_nxt = S_FLUSH;
                end else if (new_exp) begin
                  out_vld_nxt = 1'b1;
                  out_res_nxt = hold_nxt;
                  hold_vld_nxt = 1'b0;
                  state_nxt = S_IDLE;
                end else if (hold_vld_r) begin
                  out_vld_nxt = 1'b1;
                  out_res_nxt = hold_r;
                  hold_vld_nxt = 1'b0;
                  state_nxt = S_IDLE;
                end else begin
                  state_nxt = S_IDLE;
                end
              end
            end

            default: begin
              ex_vld_nxt = 1'b0;
              state_nxt  = S_IDLE;
            end
          endcase
        end
      end

      S_FLUSH: begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = hold_r;
        hold_vld_nxt = 1'b0;
        state_nxt    = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ex_vld_r     <= 1'b0;
      slot_valid_r <= '0;
      hold_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ex_vld_r     <= ex_vld_nxt;
      slot_valid_r <= slot_valid_nxt;
      hold_vld_r   <= hold_vld_nxt;
      out_vld_r    <= out_vld_nxt;
    end
    cmd_r     <= cmd_nxt;
    rd_idx_r  <= rd_idx_nxt;
    ex_idx_r  <= ex_idx_nxt;
    hold_r    <= hold_nxt;
    cnt_r     <= cnt_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ex_idx_r] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
    rd_live_r <= slot_valid_r[rd_addr];
  end

endmodule

[src/multi_slot_software_timer_table_core.sv]
`timescale 1ns / 1ps
// With the back end idle, a refused command is answered from idle without a walk; other
// commands and ticks walk the slot memory one slot a cycle, a start or restart ending at
// its answer. A tick's last expiry goes out from a flush state when the last slot expires
// behind an earlier expiry. The back end takes a new item only once done with the last;
// the queue holds two more items and the front a third.
// Reset: synchronous, active low; slot valid flags clear at once, so no clearing pass.
module multi_slot_software_timer_table_core #(
  parameter int SLOT_COUNT  = mstt_pkg::SLOT_COUNT_DEF,
  parameter int HANDLE_BITS = mstt_pkg::HANDLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  mstt_pkg::in_item_t in_item,
  output logic               busy,
  output logic               out_valid,
  output mstt_pkg::res_t     out_item
);
  import mstt_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_wdata, q_rdata;

  mstt_front #(
    .HANDLE_BITS(HANDLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  mstt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  mstt_back #(
    .SLOT_COUNT  (SLOT_COUNT),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[bench/multi_slot_software_timer_table_core_tb.sv]
`timescale 1ns / 1ps
module multi_slot_software_timer_table_core_tb;
  import mstt_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int POOL = 8;
  localparam int END_WAIT = SLOTS + 8;
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_item_t in_item = '0;
  logic busy;
  logic out_valid;
  res_t out_item;

  multi_slot_software_timer_table_core #(
    .SLOT_COUNT(SLOT_COUNT_DEF),
    .HANDLE_BITS(HANDLE_BITS_DEF)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .in_item(in_item),
    .busy(busy),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always #5 clk = ~clk;

  // shadow copy of the slot table
  logic [15:0] slot_owner [SLOTS] = '{default: '0};
  logic [31:0] slot_tag_sh [SLOTS] = '{default: '0};
  logic [31:0] slot_period_sh [SLOTS] = '{default: '0};
  logic [31:0] slot_left [SLOTS] = '{default: '0};
  bit slot_reload [SLOTS] = '{default: 1'b0};

  res_t due_results[$];
  int err_count = 0;
  bit idle_on = 1'b1;
  logic [15:0] handle_pool [POOL];

  function automatic res_t make_res(logic kind, logic ok, int slot, logic [15:0] h,
                                    logic [31:0] tg);
    res_t r;
    r.kind = kind;
    r.ok = ok;
    r.slot_index = slot[3:0];
    r.out_handle = h;
    r.out_tag = tg;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic int free_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_owner[i] == '0) n++;
    return n;
  endfunction

  // Applies one accepted item to the shadow table and queues what it should produce.
  function automatic void timer_table_step(in_item_t it);
    res_t run[$];
    res_t reply;
    bit found;
    reply = make_res(KIND_REPLY, 1'b0, 0, '0, '0);
    found = 1'b0;
    if (it.mode == MODE_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_left[i] != 0) begin
          slot_left[i] = slot_left[i] - 1;
          if (slot_left[i] == 0) begin
            if (slot_reload[i]) slot_left[i] = slot_period_sh[i];
            if (slot_owner[i] != '0 && run.size() < MAX_RESULTS)
              run.push_back(make_res(KIND_EXPIRY, 1'b1, i, slot_owner[i], slot_tag_sh[i]));
          end
        end
      end
    end else if (it.mode <= MODE_STOP) begin
      if (it.timer_handle != '0) begin
        case (it.mode)
          MODE_START_PER, MODE_START_ONE: begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!found && slot_owner[i] == '0) begin
                found = 1'b1;
                slot_owner[i] = it.timer_handle;
                slot_tag_sh[i] = it.user_tag;
                slot_period_sh[i] = it.period_ticks;
                slot_left[i] = it.period_ticks;
                slot_reload[i] = (it.mode == MODE_START_PER);
                reply = make_res(KIND_REPLY, 1'b1, i, it.timer_handle, it.user_tag);
              end
            end
          end
          MODE_RESTART: begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!found && slot_owner[i] == it.timer_handle) begin
                found = 1'b1;
                slot_left[i] = slot_period_sh[i];
                reply = make_res(KIND_REPLY, 1'b1, i, it.timer_handle, slot_tag_sh[i]);
              end
            end
          end
          default: begin
            // stop frees every match, reply names the lowest one
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_owner[i] == it.timer_handle) begin
                if (!found)
                  reply = make_res(KIND_REPLY, 1'b1, i, it.timer_handle, slot_tag_sh[i]);
                found = 1'b1;
                slot_owner[i] = '0;
                slot_tag_sh[i] = '0;
                slot_period_sh[i] = '0;
                slot_left[i] = '0;
                slot_reload[i] = 1'b0;
              end
            end
          end
        endcase
      end
      run.push_back(reply);
    end
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[k]) due_results.push_back(run[k]);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $time);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result", {31'd0, out_item.kind}, '0);
      end else begin
        want = due_results.pop_front();
        check_field("kind", 32'(out_item.kind), 32'(want.kind));
        check_field("ok", 32'(out_item.ok), 32'(want.ok));
        check_field("slot_index", 32'(out_item.slot_index), 32'(want.slot_index));
        check_field("out_handle", 32'(out_item.out_handle), 32'(want.out_handle));
        check_field("out_tag", out_item.out_tag, want.out_tag);
        check_field("last_of_run", 32'(out_item.last_of_run), 32'(want.last_of_run));
      end
    end
  end

  // One transfer, after a random run of idle cycles with start low while idle_on is set.
  task automatic xfer(logic [2:0] m, logic [15:0] h, logic [31:0] tg, logic [31:0] p);
    in_item_t it;
    it.mode = m;
    it.timer_handle = h;
    it.user_tag = tg;
    it.period_ticks = p;
    while (idle_on && $urandom_range(99) < 31) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    timer_table_step(it);
  endtask

  task automatic test_null_and_unmatched();
    xfer(MODE_TICK, '0, '0, '0);
    xfer(MODE_START_PER, 16'h0000, 32'hFFFF_FFFF, 32'd3);
    xfer(MODE_RESTART, 16'h0000, 32'h1234_5678, 32'd1);
    xfer(MODE_STOP, 16'h0000, 32'h0, 32'hFFFF_FFFF);
    xfer(MODE_RESTART, 16'h1234, 32'h0, 32'd2);
    xfer(MODE_STOP, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
    xfer(MODE_UNUSED_LAST, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_start_and_expire();
    xfer(MODE_START_PER, 16'hFFFF, 32'hFFFF_FFFF, 32'd1);
    xfer(MODE_START_ONE, 16'h0001, 32'h0000_0000, 32'd2);
    // same handle again, and a period that never runs
    xfer(MODE_START_PER, 16'h0001, 32'hA5A5_5A5A, 32'd0);
    xfer(MODE_START_ONE, 16'h8000, 32'h0000_0001, 32'hFFFF_FFFF);
    xfer(MODE_TICK, '0, '0, '0);
    xfer(MODE_TICK, '0, '0, '0);
    xfer(MODE_TICK, '0, '0, '0);
  endtask

  task automatic test_restart_and_stop();
    xfer(MODE_RESTART, 16'h0001, '0, '0);
    xfer(MODE_TICK, '0, '0, '0);
    xfer(MODE_TICK, '0, '0, '0);
    xfer(MODE_STOP, 16'h0001, '0, '0);
    xfer(MODE_START_PER, 16'h0002, 32'h5A5A_A5A5, 32'd0);
    xfer(MODE_RESTART, 16'h0002, '0, '0);
    xfer(MODE_TICK, '0, '0, '0);
    xfer(MODE_STOP, 16'h0002, '0, '0);
    xfer(MODE_STOP, 16'h8000, '0, '0);
  endtask

  // Fill every slot with period 1 so each tick expires the whole table.
  task automatic test_table_full();
    int k;
    k = 0;
    while (free_slots() > 0) begin
      xfer(MODE_START_PER, handle_pool[k % POOL], $urandom(), 32'd1);
      k++;
    end
    xfer(MODE_START_ONE, handle_pool[0], $urandom(), 32'd5);
    xfer(MODE_TICK, '0, '0, '0);
    xfer(MODE_TICK, '0, '0, '0);
    xfer(MODE_STOP, 16'hFFFF, '0, '0);
    for (int i = 0; i < POOL; i++) xfer(MODE_STOP, handle_pool[i], '0, '0);
  endtask

  task automatic test_random_mix(int n);
    int count;
    int sel;
    logic [15:0] h;
    logic [31:0] tg;
    logic [31:0] p;
    count = 0;
    while (count < n) begin
      sel = $urandom_range(99);
      h = ($urandom_range(99) < 90) ? handle_pool[$urandom_range(POOL - 1)]
                                    : 16'($urandom());
      tg = $urandom();
      sel = sel;
      if ($urandom_range(99) < 80) p = $urandom_range(5);
      else if ($urandom_range(99) < 60) p = $urandom_range(40, 6);
      else p = $urandom();
      if (sel < 6) begin
        if ($urandom_range(1)) begin
          // ignored by the block, not counted
          xfer(3'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST)), h, tg, p);
        end else begin
          xfer(3'($urandom_range(MODE_STOP, MODE_START_PER)), '0, tg, p);
          count++;
        end
      end else begin
        if (sel < 38) xfer(MODE_TICK, h, tg, p);
        else if (sel < 55) xfer(MODE_START_PER, h, tg, p);
        else if (sel < 68) xfer(MODE_START_ONE, h, tg, p);
        else if (sel < 82) xfer(MODE_RESTART, h, tg, p);
        else xfer(MODE_STOP, h, tg, p);
        count++;
      end
    end
  endtask

  initial begin
    handle_pool[0] = 16'($urandom_range(16'hFFFE, 1));
    handle_pool[1] = ~handle_pool[0];
    for (int i = 2; i < POOL; i++) handle_pool[i] = 16'($urandom_range(16'hFFFF, 1));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_null_and_unmatched();
    test_start_and_expire();
    test_restart_and_stop();
    test_table_full();
    idle_on = 1'b1;
    test_random_mix(75);
    idle_on = 1'b0;
    test_random_mix(80);
    idle_on = 1'b1;
    test_random_mix(75);

    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
